// ===== rtl/core/vnsc_pkg.sv =====
// Shared widths, codes and control types of the nearest-site classifier.
package vnsc_pkg;

  // Field widths of the item, result and register channels
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned ACTIVE_W   = 7;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned NEAREST_W  = 6;
  localparam int unsigned DIST_W     = 2 * COORD_W + 1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

  typedef enum logic [0:0] {
    FUNC_LOAD     = 1'b0,
    FUNC_CLASSIFY = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // write the item's site into the table
    logic start;        // latch the pixel, rewind the address counter
    logic issue;        // read the site at the current address and advance
    logic result_load;  // move the search result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic at_last;      // current address is the last active site
    logic scan_done;    // last distance has been compared
    logic out_free;     // output register can take a result this cycle
  } status_t;

endpackage

// ===== rtl/core/vnsc_channels.sv =====
// Handshake channel interfaces: input items, results and register writes.
interface vnsc_item_if;
  logic                               valid;
  logic                               ready;
  vnsc_pkg::func_e                    func;
  logic [vnsc_pkg::SLOT_W-1:0]        site_index;
  logic [vnsc_pkg::COORD_W-1:0]       row;
  logic [vnsc_pkg::COORD_W-1:0]       col;

  modport source (output valid, func, site_index, row, col, input ready);
  modport sink   (input valid, func, site_index, row, col, output ready);
endinterface

interface vnsc_result_if;
  logic                               valid;
  logic                               ready;
  logic                               is_site;
  logic [vnsc_pkg::COLOR_W-1:0]       color_index;
  logic [vnsc_pkg::NEAREST_W-1:0]     nearest_site;
  logic [vnsc_pkg::DIST_W-1:0]        min_distance;

  modport source (output valid, is_site, color_index, nearest_site, min_distance,
                  input ready);
  modport sink   (input valid, is_site, color_index, nearest_site, min_distance,
                  output ready);
endinterface

interface vnsc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [vnsc_pkg::ACTIVE_W-1:0]      data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/vnsc_ctrl.sv =====
// Controller state machine: sequences loads, the site scan and result hand-off.
module vnsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  vnsc_pkg::func_e    in_func_i,
  input  vnsc_pkg::status_t  status_i,
  output logic               in_ready_o,
  output vnsc_pkg::cmd_t     cmd_o
);

  vnsc_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vnsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      vnsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_func_i == vnsc_pkg::FUNC_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = vnsc_pkg::ST_SCAN;
          end
        end
      end
      vnsc_pkg::ST_SCAN: begin
        // issue one site per cycle, stop after the last active one
        cmd_o.issue = 1'b1;
        if (status_i.at_last) begin
          state_d = vnsc_pkg::ST_WAIT;
        end
      end
      vnsc_pkg::ST_WAIT: begin
        // hold until the pipeline drains and the output register is free
        if (status_i.scan_done && status_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = vnsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vnsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/vnsc_datapath.sv =====
// Datapath: site tables, distance pipeline, running minimum and result register.
module vnsc_datapath #(
  parameter int unsigned MAX_SITES       = 64,
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  vnsc_pkg::cmd_t                     cmd_i,
  output vnsc_pkg::status_t                  status_o,
  input  logic                               cfg_valid_i,
  input  logic [vnsc_pkg::ACTIVE_W-1:0]      cfg_data_i,
  input  logic [vnsc_pkg::SLOT_W-1:0]        site_index_i,
  input  logic [vnsc_pkg::COORD_W-1:0]       row_i,
  input  logic [vnsc_pkg::COORD_W-1:0]       col_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               is_site_o,
  output logic [vnsc_pkg::COLOR_W-1:0]       color_index_o,
  output logic [vnsc_pkg::NEAREST_W-1:0]     nearest_site_o,
  output logic [vnsc_pkg::DIST_W-1:0]        min_distance_o
);

  localparam int unsigned CW     = vnsc_pkg::COORD_W;
  localparam int unsigned SQ_W   = 2 * CW;
  localparam int unsigned DW     = vnsc_pkg::DIST_W;
  localparam int unsigned IDX_W  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SITES + 1);
  localparam int unsigned CMP_W  = (CNT_W > vnsc_pkg::ACTIVE_W) ? CNT_W : vnsc_pkg::ACTIVE_W;
  localparam int unsigned SCMP_W = (CNT_W > vnsc_pkg::SLOT_W) ? CNT_W : vnsc_pkg::SLOT_W;
  localparam int unsigned PAL_B  = $clog2(PALETTE_ENTRIES + 1);
  localparam int unsigned PCMP_W = (PAL_B > IDX_W) ? PAL_B : IDX_W;

  // Site tables
  logic [CW-1:0] row_mem [MAX_SITES];
  logic [CW-1:0] col_mem [MAX_SITES];

  logic [vnsc_pkg::ACTIVE_W-1:0] active_q;
  logic [IDX_W-1:0]              addr_q;
  logic [IDX_W-1:0]              last_q;
  logic [IDX_W-1:0]              last_d;
  logic [CW-1:0]                 pix_row_q, pix_col_q;

  logic [CW-1:0]                 rd_row_q, rd_col_q;
  logic                          s1_v_q, s1_last_q;
  logic [IDX_W-1:0]              s1_idx_q;

  logic [SQ_W-1:0]               sq_row_q, sq_col_q;
  logic                          s2_v_q, s2_last_q;
  logic [IDX_W-1:0]              s2_idx_q;

  logic [DW-1:0]                 best_q, best_pal_q;
  logic [IDX_W-1:0]              best_idx_q, pal_idx_q;
  logic                          done_q;
  logic                          out_valid_q;

  logic [SCMP_W-1:0]             slot_w;
  logic                          slot_ok;
  logic [CMP_W-1:0]              act_w;
  logic [CMP_W-1:0]              max_w;
  logic [CMP_W-1:0]              last_w;
  logic [CW-1:0]                 dr, dc;
  logic [SQ_W-1:0]               dr_w, dc_w;
  logic [DW-1:0]                 sum_dist;
  logic                          in_pal;

  // Active-site register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= vnsc_pkg::ACTIVE_RESET;
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  // Clamp the active count to 1..MAX_SITES and keep the last index
  always_comb begin
    act_w = CMP_W'(active_q);
    max_w = CMP_W'(MAX_SITES);
    if (act_w == '0) begin
      last_w = '0;
    end else if (act_w > max_w) begin
      last_w = max_w - CMP_W'(1);
    end else begin
      last_w = act_w - CMP_W'(1);
    end
    last_d = last_w[IDX_W-1:0];
  end

  // Drop loads beyond the table
  assign slot_w  = SCMP_W'(site_index_i);
  assign slot_ok = slot_w < SCMP_W'(MAX_SITES);

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && slot_ok) begin
      row_mem[slot_w[IDX_W-1:0]] <= row_i;
      col_mem[slot_w[IDX_W-1:0]] <= col_i;
    end
    if (cmd_i.issue) begin
      rd_row_q <= row_mem[addr_q];
      rd_col_q <= col_mem[addr_q];
    end
  end

  // Latch the pixel and scan limits at query start
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pix_row_q <= row_i;
      pix_col_q <= col_i;
      last_q    <= last_d;
    end
  end

  // Address counter and pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
      if (cmd_i.start) begin
        addr_q <= '0;
      end else if (cmd_i.issue) begin
        addr_q <= addr_q + IDX_W'(1);
      end
      if (cmd_i.start) begin
        done_q <= 1'b0;
      end else if (s2_v_q && s2_last_q) begin
        done_q <= 1'b1;
      end
    end
  end

  // Stage 1 tags travel with the read data
  always_ff @(posedge clk_i) begin
    s1_idx_q  <= addr_q;
    s1_last_q <= (addr_q == last_q);
  end

  // Stage 2: absolute differences and squares
  assign dr   = (pix_row_q >= rd_row_q) ? (pix_row_q - rd_row_q) : (rd_row_q - pix_row_q);
  assign dc   = (pix_col_q >= rd_col_q) ? (pix_col_q - rd_col_q) : (rd_col_q - pix_col_q);
  assign dr_w = SQ_W'(dr);
  assign dc_w = SQ_W'(dc);

  always_ff @(posedge clk_i) begin
    sq_row_q  <= dr_w * dr_w;
    sq_col_q  <= dc_w * dc_w;
    s2_idx_q  <= s1_idx_q;
    s2_last_q <= s1_last_q;
  end

  // Stage 3: sum and running minimum, first site always taken
  assign sum_dist = DW'(sq_row_q) + DW'(sq_col_q);
  assign in_pal   = PCMP_W'(s2_idx_q) < PCMP_W'(PALETTE_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      if ((s2_idx_q == '0) || (sum_dist < best_q)) begin
        best_q     <= sum_dist;
        best_idx_q <= s2_idx_q;
      end
      if ((s2_idx_q == '0) || (in_pal && (sum_dist < best_pal_q))) begin
        best_pal_q <= sum_dist;
        pal_idx_q  <= s2_idx_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      is_site_o      <= (best_q == '0);
      color_index_o  <= vnsc_pkg::COLOR_W'(pal_idx_q);
      nearest_site_o <= vnsc_pkg::NEAREST_W'(best_idx_q);
      min_distance_o <= best_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.at_last   = (addr_q == last_q);
  assign status_o.scan_done = done_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/core/voronoi_nearest_site_classifier.sv =====
// Top level of the nearest-site classifier: channels, controller and datapath.
//
// Usage: items arrive on item_i. A load item (func = load) writes one site
// position into the table slot site_index, and the block stays ready for the
// next item; loads whose slot lies beyond the table are dropped. A classify
// item searches the first active_sites slots for the smallest squared
// distance to (row, col), ties to the lowest index, and returns one
// transaction on result_o. cfg_i writes active_sites (0 acts as 1, values
// above the table depth act as the depth); it is always ready. The user must
// write it only while the block is idle; the block itself does not enforce this.
// The scan reads one site per cycle from the single-port site table into a
// shared square-and-compare pipeline (read, square, then sum and compare);
// no new item is taken until the query's result enters the output register.
// Reset clears the controller, the pipeline and the result valid and sets
// active_sites to 64; the site tables hold nothing until loaded. A stalled
// receiver holds the result; loads and a new query's scan continue, and that
// query's result waits until the pending transaction is taken.
module voronoi_nearest_site_classifier #(
  parameter int unsigned MAX_SITES       = 64,
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  vnsc_item_if.sink      item_i,
  vnsc_result_if.source  result_o,
  vnsc_cfg_if.sink       cfg_i
);

  vnsc_pkg::cmd_t    cmd;
  vnsc_pkg::status_t status;
  logic              in_ready;

  assign item_i.ready = in_ready;
  assign cfg_i.ready  = 1'b1;

  vnsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_func_i  (item_i.func),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  vnsc_datapath #(
    .MAX_SITES       (MAX_SITES),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_data_i     (cfg_i.data),
    .site_index_i   (item_i.site_index),
    .row_i          (item_i.row),
    .col_i          (item_i.col),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .is_site_o      (result_o.is_site),
    .color_index_o  (result_o.color_index),
    .nearest_site_o (result_o.nearest_site),
    .min_distance_o (result_o.min_distance)
  );

  // A result never overwrites a pending transaction
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.result_load |-> status.out_free)
    else $error("result loaded while output transaction pending");

  // No item is taken while the scan is issuing reads
  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |-> !cmd.issue)
    else $error("item accepted during scan");

  // A new query clears the completion flag of the previous one
  a_start_clears_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !status.scan_done)
    else $error("scan done flag survived query start");

  // The on-site flag agrees with a zero distance
  a_is_site_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.is_site == (result_o.min_distance == '0)))
    else $error("is_site disagrees with min_distance");

endmodule

// ===== tb/tb_voronoi_nearest_site_classifier.sv =====
// Testbench of the nearest-site classifier: site loads, pixel queries and active-count writes.
module tb_voronoi_nearest_site_classifier;

  localparam int unsigned MAX_SITES       = 64;
  localparam int unsigned PALETTE_ENTRIES = 16;
  localparam int unsigned COORD_MAX       = (1 << vnsc_pkg::COORD_W) - 1;
  localparam int unsigned DRAIN_CYCLES    = MAX_SITES + 8;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned DIRECTED_ROWS   = 13;

  typedef enum logic [0:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    vnsc_pkg::func_e                    func;
    logic [vnsc_pkg::SLOT_W-1:0]        site_index;
    logic [vnsc_pkg::COORD_W-1:0]       row;
    logic [vnsc_pkg::COORD_W-1:0]       col;
  } site_item_t;

  typedef struct packed {
    logic                               is_site;
    logic [vnsc_pkg::COLOR_W-1:0]       color_index;
    logic [vnsc_pkg::NEAREST_W-1:0]     nearest_site;
    logic [vnsc_pkg::DIST_W-1:0]        min_distance;
  } class_result_t;

  typedef struct packed {
    row_kind_e                          kind;
    site_item_t                         item;
    logic [vnsc_pkg::ACTIVE_W-1:0]      setting;
    logic                               typed;
    class_result_t                      want;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  vnsc_item_if   item_if ();
  vnsc_result_if result_if ();
  vnsc_cfg_if    cfg_if ();

  voronoi_nearest_site_classifier u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // Shadow copy of the site table and the active count
  logic [vnsc_pkg::COORD_W-1:0]  site_rows [MAX_SITES];
  logic [vnsc_pkg::COORD_W-1:0]  site_cols [MAX_SITES];
  logic [vnsc_pkg::ACTIVE_W-1:0] active_setting = vnsc_pkg::ACTIVE_RESET;

  class_result_t pending_results [$];
  logic          typed_flag;
  class_result_t typed_want;
  bit            no_gaps = 1'b0;

  int unsigned mismatches      = 0;
  int unsigned loads_taken     = 0;
  int unsigned queries_taken   = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned idle_cycles     = 0;

  directed_row_t directed_rows [DIRECTED_ROWS];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Nearest site over the active slots, ties to the lowest index
  function automatic class_result_t nearest_of(logic [vnsc_pkg::COORD_W-1:0] px_row,
                                               logic [vnsc_pkg::COORD_W-1:0] px_col);
    int unsigned   count;
    int unsigned   dr;
    int unsigned   dc;
    int unsigned   d_sum;
    int unsigned   best;
    int unsigned   best_pal;
    class_result_t res;
    count    = active_setting;
    best     = 0;
    best_pal = 0;
    res      = '0;
    if (count < 1) count = 1;
    if (count > MAX_SITES) count = MAX_SITES;
    for (int unsigned k = 0; k < count; k++) begin
      dr    = (px_row >= site_rows[k]) ? px_row - site_rows[k] : site_rows[k] - px_row;
      dc    = (px_col >= site_cols[k]) ? px_col - site_cols[k] : site_cols[k] - px_col;
      d_sum = dr * dr + dc * dc;
      if (k == 0 || d_sum < best) begin
        best             = d_sum;
        res.nearest_site = k[vnsc_pkg::NEAREST_W-1:0];
      end
      if (k < PALETTE_ENTRIES && (k == 0 || d_sum < best_pal)) begin
        best_pal        = d_sum;
        res.color_index = k[vnsc_pkg::COLOR_W-1:0];
      end
    end
    res.min_distance = best[vnsc_pkg::DIST_W-1:0];
    res.is_site      = (best == 0);
    return res;
  endfunction

  // Track accepted transactions, predict results and check them in order
  always @(posedge clk_i) begin
    class_result_t got;
    class_result_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        active_setting = cfg_if.data;
        cfg_writes++;
      end
      if (result_if.valid && result_if.ready) begin
        got = '{result_if.is_site, result_if.color_index, result_if.nearest_site,
                result_if.min_distance};
        if (pending_results.size() == 0) begin
          $error("result with no query outstanding: nearest_site %0d, min_distance %0d",
                 got.nearest_site, got.min_distance);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.is_site !== want.is_site) begin
            $error("is_site: expected %0d, actual %0d", want.is_site, got.is_site);
            mismatches++;
          end
          if (got.color_index !== want.color_index) begin
            $error("color_index: expected %0d, actual %0d", want.color_index,
                   got.color_index);
            mismatches++;
          end
          if (got.nearest_site !== want.nearest_site) begin
            $error("nearest_site: expected %0d, actual %0d", want.nearest_site,
                   got.nearest_site);
            mismatches++;
          end
          if (got.min_distance !== want.min_distance) begin
            $error("min_distance: expected %0d, actual %0d", want.min_distance,
                   got.min_distance);
            mismatches++;
          end
        end
      end
      if (item_if.valid && item_if.ready) begin
        if (item_if.func == vnsc_pkg::FUNC_LOAD) begin
          site_rows[item_if.site_index] = item_if.row;
          site_cols[item_if.site_index] = item_if.col;
          loads_taken++;
        end else begin
          pending_results.push_back(typed_flag ? typed_want
                                               : nearest_of(item_if.row, item_if.col));
          queries_taken++;
        end
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    result_if.ready <= no_gaps || ($urandom_range(99) >= 12);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic directed_row_t load_row(int unsigned slot, int unsigned r, int unsigned c);
    return '{ROW_ITEM, '{vnsc_pkg::FUNC_LOAD, slot[vnsc_pkg::SLOT_W-1:0],
                         r[vnsc_pkg::COORD_W-1:0], c[vnsc_pkg::COORD_W-1:0]},
             '0, 1'b0, '0};
  endfunction

  function automatic directed_row_t query_row(int unsigned r, int unsigned c);
    return '{ROW_ITEM, '{vnsc_pkg::FUNC_CLASSIFY, '0, r[vnsc_pkg::COORD_W-1:0],
                         c[vnsc_pkg::COORD_W-1:0]}, '0, 1'b0, '0};
  endfunction

  function automatic directed_row_t checked_row(int unsigned r, int unsigned c, bit on_site,
                                                int unsigned color, int unsigned near,
                                                int unsigned sq_dist);
    directed_row_t row;
    row       = query_row(r, c);
    row.typed = 1'b1;
    row.want  = '{on_site, color[vnsc_pkg::COLOR_W-1:0], near[vnsc_pkg::NEAREST_W-1:0],
                  sq_dist[vnsc_pkg::DIST_W-1:0]};
    return row;
  endfunction

  function automatic directed_row_t cfg_row(int unsigned value);
    return '{ROW_CFG, '0, value[vnsc_pkg::ACTIVE_W-1:0], 1'b0, '0};
  endfunction

  function automatic logic [vnsc_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return COORD_MAX[vnsc_pkg::COORD_W-1:0];
      default: return vnsc_pkg::COORD_W'($urandom_range(COORD_MAX));
    endcase
  endfunction

  // Move a coordinate a few steps, clamped to the grid
  function automatic logic [vnsc_pkg::COORD_W-1:0] nudge(logic [vnsc_pkg::COORD_W-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(6)) - 3;
    if (t < 0) t = 0;
    if (t > int'(COORD_MAX)) t = COORD_MAX;
    return t[vnsc_pkg::COORD_W-1:0];
  endfunction

  // Present one item, with random idle cycles first, and hold it until taken
  task automatic send_item(site_item_t it, logic typed, class_result_t want);
    while (!no_gaps && $urandom_range(99) < 12) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.func       <= it.func;
    item_if.site_index <= it.site_index;
    item_if.row        <= it.row;
    item_if.col        <= it.col;
    typed_flag         <= typed;
    typed_want         <= want;
    @(negedge clk_i);
    while (!item_if.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Write the active count once every query has been answered
  task automatic write_active(logic [vnsc_pkg::ACTIVE_W-1:0] value);
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(negedge clk_i);
    while (!cfg_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // One setting of the active count, then a mix of loads and queries
  task automatic run_phase(logic [vnsc_pkg::ACTIVE_W-1:0] setting, int unsigned n_items);
    int unsigned   span;
    int unsigned   k;
    int unsigned   sel;
    site_item_t    it;
    class_result_t none;
    none = '0;
    write_active(setting);
    span = (setting == 0) ? 1 : ((setting > MAX_SITES) ? MAX_SITES : setting);
    repeat (n_items) begin
      k   = $urandom_range(span - 1);
      sel = $urandom_range(9);
      if ($urandom_range(99) < 25) begin
        it.func       = vnsc_pkg::FUNC_LOAD;
        it.site_index = vnsc_pkg::SLOT_W'($urandom_range(MAX_SITES - 1));
        // Duplicate positions create distance ties between slots
        if (sel < 3) begin
          it.row = site_rows[k];
          it.col = site_cols[k];
        end else begin
          it.row = rand_coord();
          it.col = rand_coord();
        end
      end else begin
        it.func       = vnsc_pkg::FUNC_CLASSIFY;
        it.site_index = vnsc_pkg::SLOT_W'($urandom_range(MAX_SITES - 1));
        if (sel < 3) begin
          it.row = site_rows[k];
          it.col = site_cols[k];
        end else if (sel < 5) begin
          it.row = nudge(site_rows[k]);
          it.col = nudge(site_cols[k]);
        end else begin
          it.row = rand_coord();
          it.col = rand_coord();
        end
      end
      send_item(it, 1'b0, none);
    end
  endtask

  // Reset, directed table, table fill, then random phases
  initial begin
    site_item_t    it;
    class_result_t none;
    none = '0;

    rst_ni             <= 1'b0;
    item_if.valid      <= 1'b0;
    item_if.func       <= vnsc_pkg::FUNC_LOAD;
    item_if.site_index <= '0;
    item_if.row        <= '0;
    item_if.col        <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.data        <= '0;
    typed_flag         <= 1'b0;
    typed_want         <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_rows = '{
      cfg_row(0),                                       // zero acts as one site
      load_row(0, 0, 0),
      checked_row(0, 0, 1'b1, 0, 0, 0),                 // pixel on the site
      checked_row(COORD_MAX, COORD_MAX, 1'b0, 0, 0, 2093058),
      checked_row(0, COORD_MAX, 1'b0, 0, 0, 1046529),
      load_row(1, COORD_MAX, COORD_MAX),
      load_row(2, COORD_MAX, COORD_MAX),                // same spot as slot 1
      load_row(MAX_SITES - 1, 512, 511),
      cfg_row(3),
      checked_row(COORD_MAX, COORD_MAX, 1'b1, 1, 1, 0), // tie goes to slot 1
      checked_row(COORD_MAX, 0, 1'b0, 0, 0, 1046529),   // three-way tie
      query_row(512, 511),
      query_row(700, 300)
    };

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_active(directed_rows[i].setting);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Fill every slot so that any active count reads written sites
    for (int unsigned s = 0; s < MAX_SITES; s++) begin
      it.func       = vnsc_pkg::FUNC_LOAD;
      it.site_index = s[vnsc_pkg::SLOT_W-1:0];
      if (s > 0 && $urandom_range(7) == 0) begin
        it.row = site_rows[s - 1];
        it.col = site_cols[s - 1];
      end else begin
        it.row = rand_coord();
        it.col = rand_coord();
      end
      send_item(it, 1'b0, none);
    end

    run_phase(7'd127, 80);
    run_phase(7'd64, 80);
    no_gaps = 1'b1;
    run_phase(7'd16, 80);
    no_gaps = 1'b0;
    run_phase(7'd17, 80);
    run_phase(7'd1, 60);
    run_phase(7'd0, 60);
    run_phase(7'd2, 60);
    run_phase(7'd40, 80);
    run_phase(vnsc_pkg::ACTIVE_W'($urandom_range(1, 127)), 80);
    run_phase(7'd127, 80);

    // Drain outstanding results
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d site loads and %0d pixel queries; %0d results compared.",
             loads_taken, queries_taken, results_checked);
    $display("Active count written %0d times, from zero through the table depth to 127.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
